>>> hdl/kmct_pkg.sv
package kmct_pkg;

  typedef enum logic [1:0] {
    MODE_ENTRY = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_PAUSE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    BEEP_NONE  = 2'd0,
    BEEP_SHORT = 2'd1,
    BEEP_LONG  = 2'd2
  } beep_t;

  localparam logic       OP_KEY    = 1'b0;
  localparam logic       OP_TICK   = 1'b1;
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_CLEAR = 4'd10;
  localparam logic [3:0] KEY_START = 4'd11;
  localparam logic [3:0] TENS_MAX  = 4'd5;
  localparam logic [3:0] ONES_MAX  = 4'd9;
  localparam logic [2:0] POS_DASH  = 3'd2;
  localparam logic [2:0] POS_SEC_TENS = 3'd3;
  localparam logic [2:0] POS_SEC_ONES = 3'd4;
  localparam logic [2:0] POS_FULL  = 3'd5;

  typedef logic [3:0] bcd_t;
  // index 0 minute tens, 1 minute ones, 2 second tens, 3 second ones
  typedef bcd_t [3:0] digits_t;

  typedef struct packed {
    logic    zero;
    digits_t digits;
  } step_t;

  // one countdown step with borrows; zero flags a time already at 00-00
  function automatic step_t count_step(digits_t d);
    step_t s;
    s.zero   = (d == '0);
    s.digits = d;
    if (!s.zero) begin
      if (d[3] != '0) begin
        s.digits[3] = d[3] - 4'd1;
      end else begin
        s.digits[3] = ONES_MAX;
        if (d[2] != '0) begin
          s.digits[2] = d[2] - 4'd1;
        end else begin
          s.digits[2] = TENS_MAX;
          if (d[1] != '0) begin
            s.digits[1] = d[1] - 4'd1;
          end else begin
            s.digits[1] = ONES_MAX;
            if (d[0] != '0) begin
              s.digits[0] = d[0] - 4'd1;
            end
          end
        end
      end
    end
    return s;
  endfunction

endpackage

>>> hdl/keypad_mmss_countdown_timer_unit.sv
// channel | ports                                   | direction
// in      | in_valid in_ready in_op in_key_code     | event in
// out     | out_valid out_ready out_mode ... out_finished | result out
//
// one result per item, next cycle after accept; one item per cycle while not stalled
// the whole update is one pass of logic from the state registers to the result register
// synchronous active-low reset: entry mode, empty entry, all digits zero
// a new item is taken while the held result is being taken in the same cycle
// a stalled result blocks new items only while out_ready stays low
module keypad_mmss_countdown_timer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [3:0] in_key_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_mode,
  output logic       out_relay_on,
  output logic [2:0] out_entered_count,
  output logic [3:0] out_min_tens,
  output logic [3:0] out_min_ones,
  output logic [3:0] out_sec_tens,
  output logic [3:0] out_sec_ones,
  output logic [1:0] out_beep,
  output logic       out_finished
);
  import kmct_pkg::*;

  mode_t   mode_r, mode_nxt;
  logic [2:0] pos_r, pos_nxt;
  digits_t entry_r, entry_nxt;
  digits_t rem_r, rem_nxt;
  beep_t   beep_nxt;
  logic    fin_nxt;

  logic       out_valid_r;
  logic [1:0] out_mode_r, out_mode_nxt;
  logic       out_relay_r, out_relay_nxt;
  logic [2:0] out_count_r, out_count_nxt;
  digits_t    out_digits_r, out_digits_nxt;
  logic [1:0] out_beep_r;
  logic       out_fin_r;

  step_t      run_step, start_step;
  logic [2:0] x;
  logic       tens;
  logic [2:0] slot_pos;
  logic       accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign run_step   = count_step(rem_r);
  assign start_step = count_step(entry_r);

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    entry_nxt = entry_r;
    rem_nxt   = rem_r;
    beep_nxt  = BEEP_NONE;
    fin_nxt   = 1'b0;
    x         = pos_r;
    tens      = (pos_r == 3'd0) || (pos_r == POS_SEC_TENS);
    slot_pos  = (pos_r < POS_DASH) ? pos_r : pos_r - 3'd1;
    unique case (mode_r)
      MODE_RUN: begin
        if (in_op == OP_TICK) begin
          rem_nxt = run_step.digits;
          if (run_step.zero) begin
            mode_nxt = MODE_ENTRY;
            pos_nxt  = '0;
            beep_nxt = BEEP_LONG;
            fin_nxt  = 1'b1;
          end
        end else if (in_key_code == KEY_START) begin
          mode_nxt = MODE_PAUSE;
          beep_nxt = BEEP_SHORT;
        end
      end
      MODE_PAUSE: begin
        if (in_op == OP_KEY && in_key_code == KEY_START) begin
          mode_nxt = MODE_RUN;
          beep_nxt = BEEP_SHORT;
          rem_nxt  = run_step.digits;
          if (run_step.zero) begin
            mode_nxt = MODE_ENTRY;
            pos_nxt  = '0;
            beep_nxt = BEEP_LONG;
            fin_nxt  = 1'b1;
          end
        end else if (in_op == OP_KEY && in_key_code == KEY_CLEAR) begin
          mode_nxt = MODE_ENTRY;
          pos_nxt  = '0;
          beep_nxt = BEEP_LONG;
        end
      end
      default: begin
        if (in_op == OP_KEY) begin
          if (in_key_code <= KEY_DIGIT_MAX) begin
            if (x < POS_FULL && x != POS_DASH && !(tens && in_key_code > TENS_MAX)) begin
              entry_nxt[slot_pos[1:0]] = in_key_code;
              x = x + 3'd1;
            end
          end else if (in_key_code == KEY_CLEAR) begin
            if (x == POS_SEC_TENS) begin
              x = POS_DASH;
            end
            if (x != '0) begin
              x = x - 3'd1;
            end
          end else if (in_key_code == KEY_START && x >= POS_FULL) begin
            rem_nxt  = start_step.digits;
            mode_nxt = MODE_RUN;
            beep_nxt = BEEP_SHORT;
            if (start_step.zero) begin
              x        = '0;
              mode_nxt = MODE_ENTRY;
              beep_nxt = BEEP_LONG;
              fin_nxt  = 1'b1;
            end
          end
          if (x == POS_DASH) begin
            x = POS_SEC_TENS;
          end
          if (x > POS_FULL) begin
            x = POS_FULL;
          end
          pos_nxt = x;
        end
      end
    endcase
  end

  // result fields
  always_comb begin
    out_digits_nxt = '0;
    if (mode_nxt == MODE_RUN || mode_nxt == MODE_PAUSE) begin
      out_mode_nxt   = mode_nxt;
      out_relay_nxt  = (mode_nxt == MODE_RUN);
      out_count_nxt  = '0;
      out_digits_nxt = rem_nxt;
    end else begin
      out_mode_nxt  = MODE_ENTRY;
      out_relay_nxt = 1'b0;
      out_count_nxt = pos_nxt;
      if (pos_nxt >= 3'd1) begin
        out_digits_nxt[0] = entry_nxt[0];
      end
      if (pos_nxt >= POS_DASH) begin
        out_digits_nxt[1] = entry_nxt[1];
      end
      if (pos_nxt >= POS_SEC_ONES) begin
        out_digits_nxt[2] = entry_nxt[2];
      end
      if (pos_nxt >= POS_FULL) begin
        out_digits_nxt[3] = entry_nxt[3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_ENTRY;
      pos_r       <= '0;
      entry_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r      <= mode_nxt;
        pos_r       <= pos_nxt;
        entry_r     <= entry_nxt;
        rem_r       <= rem_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_mode_r   <= out_mode_nxt;
      out_relay_r  <= out_relay_nxt;
      out_count_r  <= out_count_nxt;
      out_digits_r <= out_digits_nxt;
      out_beep_r   <= beep_nxt;
      out_fin_r    <= fin_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mode          = out_mode_r;
  assign out_relay_on      = out_relay_r;
  assign out_entered_count = out_count_r;
  assign out_min_tens      = out_digits_r[0];
  assign out_min_ones      = out_digits_r[1];
  assign out_sec_tens      = out_digits_r[2];
  assign out_sec_ones      = out_digits_r[3];
  assign out_beep          = out_beep_r;
  assign out_finished      = out_fin_r;

`ifndef SYNTHESIS
  a_relay_only_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_relay_on == (out_mode == MODE_RUN)))
    else $error("relay state disagrees with mode");

  a_finish_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |->
      (out_beep == BEEP_LONG && out_mode == MODE_ENTRY && out_entered_count == '0))
    else $error("finish without long beep and return to entry");

  a_count_only_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entered_count != '0) |->
      (out_mode == MODE_ENTRY && out_entered_count != POS_DASH
       && out_entered_count <= POS_FULL))
    else $error("bad entered count");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted item gave no result");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) |=> ($stable(mode_r) && $stable(pos_r) && $stable(rem_r)))
    else $error("state changed without an item");
`endif

endmodule

>>> verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kmct_pkg::*;

  typedef struct packed {
    logic [1:0] mode;
    logic       relay_on;
    logic [2:0] entered_count;
    bcd_t       min_tens;
    bcd_t       min_ones;
    bcd_t       sec_tens;
    bcd_t       sec_ones;
    logic [1:0] beep;
    logic       finished;
  } timer_result_t;

  class timer_checker;
    mode_t         mode_q;
    logic [2:0]    pos_q;
    bcd_t          entry_q [4];
    bcd_t          remain_q [4];
    timer_result_t expected_results [$];
    int            errors;
    int            results_checked;
    int            finishes;
    int            pauses;

    function new();
      mode_q = MODE_ENTRY;
      pos_q  = 3'd0;
      foreach (entry_q[i]) entry_q[i] = 4'd0;
      foreach (remain_q[i]) remain_q[i] = 4'd0;
      errors = 0;
      results_checked = 0;
      finishes = 0;
      pauses = 0;
    endfunction

    // one bcd step down; returns 1 when the time was already zero
    function bit count_down();
      if (remain_q[0] == 0 && remain_q[1] == 0 && remain_q[2] == 0 && remain_q[3] == 0)
        return 1'b1;
      if (remain_q[3] != 0) begin
        remain_q[3] = remain_q[3] - 4'd1;
        return 1'b0;
      end
      remain_q[3] = ONES_MAX;
      if (remain_q[2] != 0) begin
        remain_q[2] = remain_q[2] - 4'd1;
        return 1'b0;
      end
      remain_q[2] = TENS_MAX;
      if (remain_q[1] != 0) begin
        remain_q[1] = remain_q[1] - 4'd1;
        return 1'b0;
      end
      remain_q[1] = ONES_MAX;
      if (remain_q[0] != 0) remain_q[0] = remain_q[0] - 4'd1;
      return 1'b0;
    endfunction

    // returns 1 when the item changed anything or beeped
    function bit note_input(logic op, logic [3:0] key);
      logic [2:0]    x;
      mode_t         old_mode;
      logic [2:0]    old_pos;
      bcd_t          old_remain [4];
      beep_t         beep;
      logic          fin;
      bit            tens;
      timer_result_t r;
      old_mode   = mode_q;
      old_pos    = pos_q;
      old_remain = remain_q;
      beep       = BEEP_NONE;
      fin        = 1'b0;
      x          = pos_q;
      case (mode_q)
        MODE_RUN: begin
          if (op == OP_TICK) begin
            if (count_down()) begin
              mode_q = MODE_ENTRY;
              pos_q  = 3'd0;
              beep   = BEEP_LONG;
              fin    = 1'b1;
            end
          end else if (key == KEY_START) begin
            mode_q = MODE_PAUSE;
            beep   = BEEP_SHORT;
          end
        end
        MODE_PAUSE: begin
          if (op == OP_KEY && key == KEY_START) begin
            mode_q = MODE_RUN;
            beep   = BEEP_SHORT;
            if (count_down()) begin
              mode_q = MODE_ENTRY;
              pos_q  = 3'd0;
              beep   = BEEP_LONG;
              fin    = 1'b1;
            end
          end else if (op == OP_KEY && key == KEY_CLEAR) begin
            mode_q = MODE_ENTRY;
            pos_q  = 3'd0;
            beep   = BEEP_LONG;
          end
        end
        default: begin
          if (op == OP_KEY) begin
            if (key <= KEY_DIGIT_MAX) begin
              tens = (x == 3'd0 || x == POS_SEC_TENS);
              if (x < POS_FULL && x != POS_DASH && !(tens && key > TENS_MAX)) begin
                if (x < POS_DASH) entry_q[x] = key;
                else entry_q[x - 3'd1] = key;
                x = x + 3'd1;
              end
            end else if (key == KEY_CLEAR) begin
              if (x == POS_SEC_TENS) x = POS_DASH;
              if (x != 3'd0) x = x - 3'd1;
            end else if (key == KEY_START && x >= POS_FULL) begin
              remain_q = entry_q;
              mode_q   = MODE_RUN;
              beep     = BEEP_SHORT;
              if (count_down()) begin
                x      = 3'd0;
                mode_q = MODE_ENTRY;
                beep   = BEEP_LONG;
                fin    = 1'b1;
              end
            end
            if (x == POS_DASH) x = POS_SEC_TENS;
            if (x > POS_FULL) x = POS_FULL;
            pos_q = x;
          end
        end
      endcase

      if (mode_q == MODE_RUN || mode_q == MODE_PAUSE) begin
        r.mode          = mode_q;
        r.relay_on      = (mode_q == MODE_RUN);
        r.entered_count = 3'd0;
        r.min_tens      = remain_q[0];
        r.min_ones      = remain_q[1];
        r.sec_tens      = remain_q[2];
        r.sec_ones      = remain_q[3];
      end else begin
        r.mode          = MODE_ENTRY;
        r.relay_on      = 1'b0;
        r.entered_count = pos_q;
        r.min_tens      = (pos_q >= 3'd1) ? entry_q[0] : 4'd0;
        r.min_ones      = (pos_q >= 3'd2) ? entry_q[1] : 4'd0;
        r.sec_tens      = (pos_q >= POS_SEC_ONES) ? entry_q[2] : 4'd0;
        r.sec_ones      = (pos_q >= POS_FULL) ? entry_q[3] : 4'd0;
      end
      r.beep     = beep;
      r.finished = fin;
      expected_results.push_back(r);
      if (fin) finishes++;
      if (mode_q == MODE_PAUSE && old_mode == MODE_RUN) pauses++;
      return beep != BEEP_NONE || mode_q != old_mode || pos_q != old_pos ||
             remain_q != old_remain;
    endfunction

    function void check_field(string field, int want, int got);
      if (want != got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result with no item pending, expected none actual %h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      results_checked++;
      check_field("mode", want.mode, got.mode);
      check_field("relay_on", want.relay_on, got.relay_on);
      check_field("entered_count", want.entered_count, got.entered_count);
      check_field("min_tens", want.min_tens, got.min_tens);
      check_field("min_ones", want.min_ones, got.min_ones);
      check_field("sec_tens", want.sec_tens, got.sec_tens);
      check_field("sec_ones", want.sec_ones, got.sec_ones);
      check_field("beep", want.beep, got.beep);
      check_field("finished", want.finished, got.finished);
    endfunction
  endclass

  localparam int STALL_LIMIT = 1000;
  localparam int ITEM_TARGET = 1950;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_op = OP_KEY;
  logic [3:0] in_key_code = 4'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_mode;
  logic       out_relay_on;
  logic [2:0] out_entered_count;
  logic [3:0] out_min_tens;
  logic [3:0] out_min_ones;
  logic [3:0] out_sec_tens;
  logic [3:0] out_sec_ones;
  logic [1:0] out_beep;
  logic       out_finished;

  timer_checker timer_chk = new();
  bit           calm = 1'b0;
  int           items_sent = 0;
  int           acted_items = 0;
  int           stall_cycles = 0;
  int           sessions = 0;

  keypad_mmss_countdown_timer_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_key_code       (in_key_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mode          (out_mode),
    .out_relay_on      (out_relay_on),
    .out_entered_count (out_entered_count),
    .out_min_tens      (out_min_tens),
    .out_min_ones      (out_min_ones),
    .out_sec_tens      (out_sec_tens),
    .out_sec_ones      (out_sec_ones),
    .out_beep          (out_beep),
    .out_finished      (out_finished)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: check and stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      timer_chk.check_result({out_mode, out_relay_on, out_entered_count, out_min_tens,
                              out_min_ones, out_sec_tens, out_sec_ones, out_beep,
                              out_finished});
    out_ready <= rst_n && (calm || $urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic op, input logic [3:0] key);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_key_code <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (timer_chk.note_input(op, key)) acted_items++;
  endtask

  task automatic press(input logic [3:0] key);
    send_item(OP_KEY, key);
  endtask

  // the key field of a tick carries random bits
  task automatic tick();
    send_item(OP_TICK, 4'($urandom_range(15)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (timer_chk.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic enter_time(input bcd_t mt, input bcd_t mo, input bcd_t st, input bcd_t so);
    bcd_t        want;
    int unsigned r;
    while (timer_chk.mode_q == MODE_ENTRY && timer_chk.pos_q != POS_FULL) begin
      case (timer_chk.pos_q)
        3'd0:         want = mt;
        3'd1:         want = mo;
        POS_SEC_TENS: want = st;
        default:      want = so;
      endcase
      r = $urandom_range(99);
      if (r < 85) press(want);
      else if (r < 90) press(KEY_CLEAR);
      else if (r < 95) press(4'($urandom_range(6, 9)));
      else if (r < 98) press(4'($urandom_range(12, 15)));
      else tick();
    end
  endtask

  task automatic run_session();
    bcd_t        mt, mo, st, so;
    int          budget;
    int unsigned r;
    if ($urandom_range(99) < 80) begin
      mt = 4'd0;
      mo = 4'd0;
    end else begin
      mt = 4'($urandom_range(5));
      mo = 4'($urandom_range(9));
    end
    st = 4'($urandom_range(5));
    so = 4'($urandom_range(9));
    // noise may have left a countdown going
    if (timer_chk.mode_q == MODE_RUN) press(KEY_START);
    if (timer_chk.mode_q == MODE_PAUSE) press(KEY_CLEAR);
    while (timer_chk.pos_q != 3'd0) press(KEY_CLEAR);
    enter_time(mt, mo, st, so);
    press(KEY_START);
    budget = $urandom_range(90);
    while (timer_chk.mode_q != MODE_ENTRY && budget > 0) begin
      r = $urandom_range(99);
      if (r < 82) tick();
      else if (r < 88) press(KEY_START);
      else if (r < 91) press(KEY_CLEAR);
      else press(4'($urandom_range(15)));
      budget--;
    end
    if (timer_chk.mode_q == MODE_RUN) press(KEY_START);
    if (timer_chk.mode_q == MODE_PAUSE) press(KEY_CLEAR);
  endtask

  task automatic noise_burst(input int n);
    repeat (n) send_item(1'($urandom_range(1)), 4'($urandom_range(15)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // ignored items on an empty entry
    tick();
    press(KEY_CLEAR);
    press(KEY_START);
    // tens limit, auto dash, clear over the dash, full entry
    press(4'd7);
    press(4'd5);
    press(4'd9);
    press(KEY_CLEAR);
    press(4'd9);
    press(4'd6);
    press(4'd5);
    press(4'd9);
    press(4'd3);
    press(4'd15);
    // run, pause, resume, reset
    press(KEY_START);
    tick();
    press(4'd4);
    press(KEY_CLEAR);
    press(KEY_START);
    tick();
    press(4'd8);
    press(KEY_START);
    press(KEY_START);
    press(KEY_CLEAR);
    // start on zero finishes at once
    press(4'd0);
    press(4'd0);
    press(4'd0);
    press(4'd0);
    press(KEY_START);

    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent >= 800 && items_sent < 1100);
      if ($urandom_range(99) < 85) begin
        run_session();
        sessions++;
        if (sessions % 40 == 0) drain();
      end else begin
        noise_burst($urandom_range(1, 8));
      end
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    $display("%0d items driven (%0d of them changed state) over %0d countdown sessions",
             items_sent, acted_items, sessions);
    $display("%0d results checked, %0d countdowns finished, %0d pauses",
             timer_chk.results_checked, timer_chk.finishes, timer_chk.pauses);
    if (timer_chk.errors == 0 && timer_chk.expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
